// ----- design/sat_pkg.sv -----
// sat_pkg: shared constants and types for the separating axis polygon test
// no dependencies
`timescale 1ns / 1ps
`default_nettype none
package sat_pkg;
    localparam int MaxVertices = 8;
    localparam int CoordBits = 16;
    localparam int FieldBits = 16;
    localparam int DepthBits = 18;
    localparam int NormBits = 16;
    localparam logic [DepthBits-1:0] DepthMax = '1;
    localparam logic signed [NormBits-1:0] UnitQ14 = 16'sd16384;

    localparam logic [1:0] FUNC_V1 = 2'd0;
    localparam logic [1:0] FUNC_V2 = 2'd1;
    localparam logic [1:0] FUNC_C1 = 2'd2;
    localparam logic [1:0] FUNC_C2 = 2'd3;

    // request to the shared divide unit
    typedef struct packed {
        logic        start;
        logic [63:0] num;
        logic [35:0] den;
    } t_div_req;

    typedef struct packed {
        logic        done;
        logic [35:0] quo;
    } t_div_rsp;
endpackage
`default_nettype wire

// ----- design/sat_sqrt.sv -----
// sat_sqrt: bit-serial integer square root, one result bit per cycle
// depends on sat_pkg
`timescale 1ns / 1ps
`default_nettype none
module sat_sqrt
    import sat_pkg::*;
(
    input  wire         i_clk,
    input  wire         i_rst_n,
    input  wire         i_start,
    input  wire  [63:0] i_val,
    output logic        o_done,
    output logic [31:0] o_root
);
    logic [63:0] r_rem, n_rem;
    logic [31:0] r_root, n_root;
    logic [5:0]  r_cnt, n_cnt;
    logic        r_busy, n_busy, r_done, n_done;
    logic [63:0] r_val, n_val;
    logic [65:0] w_trial;
    logic [65:0] w_cur;

    // restoring square root, two radicand bits per step
    always_comb begin
        w_cur   = {r_rem[63:0], r_val[63:62]};
        w_trial = w_cur - {32'd0, r_root, 2'b01};
        n_rem = r_rem; n_root = r_root; n_cnt = r_cnt; n_busy = r_busy;
        n_val = r_val; n_done = 1'b0;
        if (i_start) begin
            n_rem = '0; n_root = '0; n_cnt = 6'd0; n_busy = 1'b1; n_val = i_val;
        end else if (r_busy) begin
            n_val = {r_val[61:0], 2'b00};
            if (!w_trial[65]) begin
                n_rem  = w_trial[63:0];
                n_root = {r_root[30:0], 1'b1};
            end else begin
                n_rem  = w_cur[63:0];
                n_root = {r_root[30:0], 1'b0};
            end
            n_cnt = r_cnt + 6'd1;
            if (r_cnt == 6'd31) begin
                n_busy = 1'b0; n_done = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0; r_done <= 1'b0; r_cnt <= '0;
        end else begin
            r_busy <= n_busy; r_done <= n_done; r_cnt <= n_cnt;
        end
        r_rem <= n_rem; r_root <= n_root; r_val <= n_val;
    end

    assign o_done = r_done;
    assign o_root = r_root;
endmodule
`default_nettype wire

// ----- design/sat_div.sv -----
// sat_div: restoring divider, one quotient bit per cycle
// depends on sat_pkg
`timescale 1ns / 1ps
`default_nettype none
module sat_div
    import sat_pkg::*;
(
    input  wire      i_clk,
    input  wire      i_rst_n,
    input  t_div_req i_req,
    output t_div_rsp o_rsp
);
    logic [63:0] r_num, n_num;
    logic [35:0] r_den, n_den;
    logic [36:0] r_rem, n_rem;
    logic [35:0] r_quo, n_quo;
    logic [6:0]  r_cnt, n_cnt;
    logic        r_busy, n_busy, r_done, n_done;
    logic [37:0] w_sh, w_diff;

    // shift in numerator bits, keep low quotient bits (result fits 36 bits)
    always_comb begin
        w_sh   = {r_rem, r_num[63]};
        w_diff = w_sh - {2'd0, r_den};
        n_num = r_num; n_den = r_den; n_rem = r_rem; n_quo = r_quo;
        n_cnt = r_cnt; n_busy = r_busy; n_done = 1'b0;
        if (i_req.start) begin
            n_num = i_req.num; n_den = i_req.den; n_rem = '0; n_quo = '0;
            n_cnt = '0; n_busy = 1'b1;
        end else if (r_busy) begin
            n_num = {r_num[62:0], 1'b0};
            if (!w_diff[37]) begin
                n_rem = w_diff[36:0]; n_quo = {r_quo[34:0], 1'b1};
            end else begin
                n_rem = w_sh[36:0]; n_quo = {r_quo[34:0], 1'b0};
            end
            n_cnt = r_cnt + 7'd1;
            if (r_cnt == 7'd63) begin
                n_busy = 1'b0; n_done = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0; r_done <= 1'b0; r_cnt <= '0;
        end else begin
            r_busy <= n_busy; r_done <= n_done; r_cnt <= n_cnt;
        end
        r_num <= n_num; r_den <= n_den; r_rem <= n_rem; r_quo <= n_quo;
    end

    assign o_rsp.done = r_done;
    assign o_rsp.quo  = r_quo;
endmodule
`default_nettype wire

// ----- design/separating_axis_polygon_test.sv -----
// separating axis test for two convex polygons, loaded one item at a time
// each usable edge axis takes a square root, two divides and a walk over both vertex sets;
// a zero-length edge skips them
// a separating axis ends the walk early; no item is taken while a test runs or a result waits
// synchronous active-low reset clears counts, centres and control state;
// the vertex memory is undefined until written
`timescale 1ns / 1ps
`default_nettype none
module separating_axis_polygon_test
    import sat_pkg::*;
#(
    parameter int MAX_VERTICES = MaxVertices,
    parameter int COORD_BITS   = CoordBits
) (
    input  wire         i_clk,
    input  wire         i_rst_n,
    input  wire         s_axis_tvalid,
    output logic        s_axis_tready,
    input  wire  [31:0] s_axis_tdata,  // coord_x[15:0], coord_y[31:16]
    input  wire  [1:0]  s_axis_tuser,  // func[1:0]
    input  wire         s_axis_tlast,
    output logic        m_axis_tvalid,
    input  wire         m_axis_tready,
    output logic [55:0] m_axis_tdata   // depth[17:0], normal_x[33:18], normal_y[49:34]
    ,output logic       m_axis_tuser   // collided
);
    localparam int CB = (COORD_BITS < FieldBits) ? COORD_BITS : FieldBits;
    localparam int AW = $clog2(2 * MAX_VERTICES);
    localparam int CW = $clog2(MAX_VERTICES + 1);
    localparam logic [AW-1:0] Base2 = AW'(MAX_VERTICES);
    localparam logic [CW-1:0] CMax = CW'(MAX_VERTICES);

    typedef enum logic [10:0] {
        ST_LOAD  = 11'b00000000001,
        ST_EDGEA = 11'b00000000010,
        ST_EDGEB = 11'b00000000100,
        ST_SQ    = 11'b00000001000,
        ST_ROOT  = 11'b00000010000,
        ST_DIVX  = 11'b00000100000,
        ST_DIVY  = 11'b00001000000,
        ST_PROJ  = 11'b00010000000,
        ST_EVAL  = 11'b00100000000,
        ST_FLIP  = 11'b01000000000,
        ST_OUT   = 11'b10000000000
    } t_state;

    t_state r_st, n_st;
    logic [15:0] r_mx [2*MAX_VERTICES];
    logic [15:0] r_my [2*MAX_VERTICES];
    logic signed [15:0] r_rx, r_ry;
    logic [CW-1:0] r_c1, r_c2, n_c1, n_c2;
    logic signed [15:0] r_cx [2];
    logic signed [15:0] r_cy [2];
    logic signed [15:0] w_x, w_y;
    logic w_acc;

    // per-axis registers
    logic          r_poly;
    logic [CW-1:0] r_a, r_v;
    logic signed [15:0] r_ax, r_ay;
    logic signed [16:0] r_dx, r_dy;
    logic [31:0]   r_q;
    logic signed [15:0] r_nx, r_ny;
    logic          r_axis;
    logic          r_pset, r_pside;
    logic signed [36:0] r_lo1, r_hi1, r_lo2, r_hi2;
    logic          r_have;
    logic signed [37:0] r_best;
    logic signed [15:0] r_bnx, r_bny;
    logic          r_col;
    logic [DepthBits-1:0] r_dep;
    logic          r_ovalid;

    t_div_req w_dreq;
    t_div_rsp w_drsp;
    logic        w_sq_start, w_sq_done;
    logic [31:0] w_root;

    // edge vector and its squared length
    logic signed [16:0] w_dx, w_dy;
    logic signed [33:0] w_px, w_py;
    logic [33:0] w_s;
    logic        w_zero;

    assign w_x   = 16'($signed(s_axis_tdata[CB-1:0]));
    assign w_y   = 16'($signed(s_axis_tdata[16+CB-1:16]));
    assign s_axis_tready = (r_st == ST_LOAD) && !r_ovalid;
    assign w_acc = s_axis_tvalid && s_axis_tready;

    assign w_dx   = 17'(r_rx) - 17'(r_ax);
    assign w_dy   = 17'(r_ry) - 17'(r_ay);
    assign w_px   = w_dx * w_dx;
    assign w_py   = w_dy * w_dy;
    assign w_s    = $unsigned(w_px) + $unsigned(w_py);
    assign w_zero = (r_rx == r_ax) && (r_ry == r_ay);

    sat_sqrt u_sqrt (.i_clk(i_clk), .i_rst_n(i_rst_n), .i_start(w_sq_start),
                     .i_val({2'd0, w_s, 28'd0}), .o_done(w_sq_done),
                     .o_root(w_root));
    sat_div u_div (.i_clk(i_clk), .i_rst_n(i_rst_n), .i_req(w_dreq), .o_rsp(w_drsp));

    // divide request: (|c| << 28 + q/2) / q
    logic signed [16:0] w_comp;
    logic [16:0] w_mag;
    logic [31:0] w_den;
    assign w_comp = (r_st == ST_ROOT) ? -r_dy : r_dx;
    assign w_mag  = w_comp[16] ? 17'(-w_comp) : 17'(w_comp);
    assign w_den  = (r_st == ST_ROOT) ? w_root : r_q;
    assign w_sq_start = (r_st == ST_SQ) && !w_zero;
    always_comb begin
        w_dreq.start = (r_st == ST_ROOT && w_sq_done) ||
                       (r_st == ST_DIVX && w_drsp.done);
        w_dreq.num = {19'd0, w_mag, 28'd0} + {33'd0, w_den[31:1]};
        w_dreq.den = {4'd0, w_den};
    end

    logic signed [15:0] w_unit;
    assign w_unit = (w_drsp.quo > 36'd16384) ? UnitQ14 : 16'(w_drsp.quo);

    // projection of the addressed vertex
    logic [AW-1:0] w_paddr;
    logic signed [36:0] w_prj;
    logic [CW-1:0] w_pcnt;
    logic w_plast, w_first;
    assign w_paddr = r_pside ? AW'(Base2 + AW'(r_v)) : AW'(r_v);
    assign w_prj = 37'($signed(r_rx)) * r_nx + 37'($signed(r_ry)) * r_ny;
    assign w_pcnt  = r_pside ? r_c2 : r_c1;
    assign w_plast = (r_v == w_pcnt);
    assign w_first = (r_v == CW'(1));

    logic signed [37:0] w_o1, w_o2, w_d, w_flipdot;
    logic [37:0] w_dq;
    logic w_sep;
    assign w_o1 = 38'(r_hi2) - 38'(r_lo1);
    assign w_o2 = 38'(r_hi1) - 38'(r_lo2);
    assign w_d  = (w_o2 < w_o1) ? w_o2 : w_o1;
    assign w_sep = !(r_hi2 >= r_lo1 && r_hi1 >= r_lo2);
    assign w_flipdot = 38'(17'(r_cx[1]) - 17'(r_cx[0])) * r_bnx +
                       38'(17'(r_cy[1]) - 17'(r_cy[0])) * r_bny;
    assign w_dq = 38'(r_best + 38'sd8192) >> 14;

    logic [AW-1:0] w_ea, w_eb;
    logic [CW-1:0] w_cnt, w_bi;
    logic w_elast;
    assign w_cnt = r_poly ? r_c2 : r_c1;
    assign w_elast = (r_a + 1'b1 == w_cnt);
    assign w_bi  = w_elast ? '0 : CW'(r_a + 1'b1);
    assign w_ea  = r_poly ? AW'(Base2 + AW'(r_a)) : AW'(r_a);
    assign w_eb  = r_poly ? AW'(Base2 + AW'(w_bi)) : AW'(w_bi);

    // vertex memory, registered read
    logic [AW-1:0] w_raddr;
    assign w_raddr = (r_st == ST_EDGEA) ? w_ea : (r_st == ST_EDGEB) ? w_eb : w_paddr;
    always_ff @(posedge i_clk) begin
        if (w_acc && s_axis_tuser == FUNC_V1 && r_c1 < CMax) begin
            r_mx[AW'(r_c1)] <= w_x; r_my[AW'(r_c1)] <= w_y;
        end else if (w_acc && s_axis_tuser == FUNC_V2 && r_c2 < CMax) begin
            r_mx[AW'(Base2 + AW'(r_c2))] <= w_x; r_my[AW'(Base2 + AW'(r_c2))] <= w_y;
        end
        r_rx <= r_mx[w_raddr];
        r_ry <= r_my[w_raddr];
    end

    // sequencer
    logic w_go;
    assign w_go = w_acc && s_axis_tlast;
    always_comb begin
        n_c1 = r_c1; n_c2 = r_c2;
        if (w_acc && s_axis_tuser == FUNC_V1 && r_c1 < CMax) n_c1 = r_c1 + 1'b1;
        if (w_acc && s_axis_tuser == FUNC_V2 && r_c2 < CMax) n_c2 = r_c2 + 1'b1;
        if (r_st == ST_OUT) begin
            n_c1 = '0; n_c2 = '0;
        end
        n_st = r_st;
        case (r_st)
            ST_LOAD:  if (w_go) n_st = (n_c1 == '0 || n_c2 == '0) ? ST_OUT : ST_EDGEA;
            ST_EDGEA: n_st = ST_EDGEB;
            ST_EDGEB: n_st = ST_SQ;
            ST_SQ:    n_st = w_zero ? ST_EVAL : ST_ROOT;
            ST_ROOT:  if (w_sq_done) n_st = ST_DIVX;
            ST_DIVX:  if (w_drsp.done) n_st = ST_DIVY;
            ST_DIVY:  if (w_drsp.done) n_st = ST_PROJ;
            ST_PROJ:  if (w_plast && r_pside) n_st = ST_EVAL;
            ST_EVAL: begin
                if (r_axis && w_sep) n_st = ST_OUT;
                else if (w_elast && r_poly) n_st = ST_FLIP;
                else n_st = ST_EDGEA;
            end
            ST_FLIP:  n_st = ST_OUT;
            ST_OUT:   n_st = ST_LOAD;
            default:  n_st = ST_LOAD;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st <= ST_LOAD; r_c1 <= '0; r_c2 <= '0; r_ovalid <= 1'b0;
            r_cx[0] <= '0; r_cx[1] <= '0; r_cy[0] <= '0; r_cy[1] <= '0;
            r_have <= 1'b0; r_col <= 1'b0; r_poly <= 1'b0; r_a <= '0;
            r_pset <= 1'b0; r_axis <= 1'b0; r_pside <= 1'b0; r_v <= '0;
        end else begin
            r_st <= n_st; r_c1 <= n_c1; r_c2 <= n_c2;
            if (r_st == ST_OUT) r_ovalid <= 1'b1;
            else if (r_ovalid && m_axis_tready) r_ovalid <= 1'b0;
            if (w_acc && s_axis_tuser == FUNC_C1) begin r_cx[0] <= w_x; r_cy[0] <= w_y; end
            if (w_acc && s_axis_tuser == FUNC_C2) begin r_cx[1] <= w_x; r_cy[1] <= w_y; end
            case (r_st)
                ST_LOAD: if (w_go) begin
                    r_poly <= 1'b0; r_a <= '0; r_have <= 1'b0; r_col <= 1'b0;
                end
                ST_EDGEA: ;
                ST_EDGEB: begin r_ax <= r_rx; r_ay <= r_ry; end
                ST_SQ: begin
                    r_dx <= w_dx; r_dy <= w_dy;
                    r_axis <= !w_zero;
                end
                ST_ROOT: if (w_sq_done) r_q <= w_root;
                ST_DIVX: if (w_drsp.done) r_nx <= (r_dy > 0) ? -w_unit : w_unit;
                ST_DIVY: if (w_drsp.done) begin
                    r_ny <= (r_dx < 0) ? -w_unit : w_unit;
                    r_pside <= 1'b0; r_v <= '0; r_pset <= 1'b0;
                end
                ST_PROJ: begin
                    // one address per cycle; data arrives next cycle
                    if (r_pset) begin
                        if (!r_pside) begin
                            if (w_first || w_prj < r_lo1) r_lo1 <= w_prj;
                            if (w_first || w_prj > r_hi1) r_hi1 <= w_prj;
                        end else begin
                            if (w_first || w_prj < r_lo2) r_lo2 <= w_prj;
                            if (w_first || w_prj > r_hi2) r_hi2 <= w_prj;
                        end
                    end
                    if (w_plast) begin
                        r_v <= '0; r_pset <= 1'b0; r_pside <= 1'b1;
                    end else begin
                        r_v <= r_v + 1'b1; r_pset <= 1'b1;
                    end
                end
                ST_EVAL: begin
                    if (r_axis && !w_sep && (!r_have || w_d < r_best)) begin
                        r_have <= 1'b1; r_best <= w_d; r_bnx <= r_nx; r_bny <= r_ny;
                    end
                    if (w_elast) begin
                        r_a <= '0; r_poly <= 1'b1;
                    end else begin
                        r_a <= r_a + 1'b1;
                    end
                end
                ST_FLIP: begin
                    r_col <= r_have;
                    if (w_flipdot < 0) begin r_bnx <= -r_bnx; r_bny <= -r_bny; end
                    r_dep <= (w_dq > 38'(DepthMax)) ? DepthMax : DepthBits'(w_dq);
                end
                ST_OUT: ;
                default: ;
            endcase
        end
    end

    // result output
    assign m_axis_tvalid = r_ovalid;
    assign m_axis_tuser  = r_col;
    assign m_axis_tdata  = r_col ? {6'd0, r_bny, r_bnx, r_dep} : 56'd0;

`ifndef NO_ASSERTIONS
    a_no_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_st != ST_LOAD) |-> !s_axis_tready) else $error("ready while busy");
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && !m_axis_tready) |=> m_axis_tvalid) else $error("result lost");
    a_nocol_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && !m_axis_tuser) |-> (m_axis_tdata == 56'd0)) else $error("nonzero");
`endif
endmodule
`default_nettype wire

// ----- tb/sv/tb.sv -----
// tb: self-checking bench for separating_axis_polygon_test; a directed table, then random
// polygon sets, checked against a built-in fixed-point predictor or a typed expected result
// depends on sat_pkg and separating_axis_polygon_test
`timescale 1ns / 1ps
module tb
    import sat_pkg::*;
();

    localparam int CycleLimit = 10000000;
    localparam int NumItems   = 600;

    typedef struct packed {
        logic                        collided;
        logic [DepthBits-1:0]        depth;
        logic signed [NormBits-1:0]  nx;
        logic signed [NormBits-1:0]  ny;
    } t_contact;

    typedef struct {
        logic [1:0]         func;
        logic signed [15:0] x;
        logic signed [15:0] y;
        logic               last;
        logic               typed;
        t_contact           res;
    } t_row;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [31:0] s_axis_tdata = '0;
    logic [1:0]  s_axis_tuser = '0;
    logic        s_axis_tlast = 1'b0;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [55:0] m_axis_tdata;
    logic        m_axis_tuser;

    separating_axis_polygon_test DUT (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
        .s_axis_tdata(s_axis_tdata), .s_axis_tuser(s_axis_tuser),
        .s_axis_tlast(s_axis_tlast),
        .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
        .m_axis_tdata(m_axis_tdata), .m_axis_tuser(m_axis_tuser)
    );

    always #1 i_clk = ~i_clk;

    // predictor state
    logic signed [15:0] pv_x [2*MaxVertices];
    logic signed [15:0] pv_y [2*MaxVertices];
    int                 cnt1, cnt2;
    logic signed [15:0] cen_x [2];
    logic signed [15:0] cen_y [2];

    t_contact contact_q [$];
    int       errors = 0;
    int       cycles = 0;
    int       sent = 0;
    int       received = 0;
    logic     idle_on = 1'b1;

    function automatic longint unsigned root64(longint unsigned v);
        longint unsigned r, b;
        r = 0;
        b = 64'd1 << 62;
        while (b > v) b = b >> 2;
        while (b != 0) begin
            if (v >= r + b) begin
                v = v - (r + b);
                r = (r >> 1) + b;
            end else begin
                r = r >> 1;
            end
            b = b >> 2;
        end
        return r;
    endfunction

    function automatic int unit_q14(longint c, longint unsigned q);
        longint unsigned mag, r;
        mag = (c < 0) ? longint'(-c) : longint'(c);
        r = ((mag << 28) + q / 2) / q;
        if (r > 16384) r = 16384;
        return (c < 0) ? -int'(r) : int'(r);
    endfunction

    // project one stored polygon onto an axis, giving its min and max
    function automatic void span(int base, int n, int nx, int ny,
                                 output longint lo, output longint hi);
        longint p;
        lo = 0;
        hi = 0;
        for (int i = 0; i < n; i++) begin
            p = longint'(pv_x[base+i]) * nx + longint'(pv_y[base+i]) * ny;
            if (i == 0 || p < lo) lo = p;
            if (i == 0 || p > hi) hi = p;
        end
    endfunction

    function automatic t_contact predict_contact();
        t_contact          res;
        bit                have;
        longint            best, dx, dy, lo1, hi1, lo2, hi2, d, ddx, ddy;
        longint unsigned   s, q, dq;
        int                nx, ny, bnx, bny, base, n, b;
        res = '0;
        have = 0;
        best = 0;
        bnx = 0;
        bny = 0;
        if (cnt1 == 0 || cnt2 == 0) return res;
        for (int poly = 0; poly < 2; poly++) begin
            base = poly ? MaxVertices : 0;
            n = poly ? cnt2 : cnt1;
            for (int a = 0; a < n; a++) begin
                b = (a + 1 == n) ? 0 : a + 1;
                dx = longint'(pv_x[base+b]) - longint'(pv_x[base+a]);
                dy = longint'(pv_y[base+b]) - longint'(pv_y[base+a]);
                s = dx * dx + dy * dy;
                if (s == 0) continue;
                q = root64(s << 28);
                nx = unit_q14(-dy, q);
                ny = unit_q14(dx, q);
                span(0, cnt1, nx, ny, lo1, hi1);
                span(MaxVertices, cnt2, nx, ny, lo2, hi2);
                // any separating axis ends the test with no contact
                if (!(hi2 >= lo1 && hi1 >= lo2)) return '0;
                d = hi2 - lo1;
                if (hi1 - lo2 < d) d = hi1 - lo2;
                if (!have || d < best) begin
                    have = 1;
                    best = d;
                    bnx = nx;
                    bny = ny;
                end
            end
        end
        if (!have) return res;
        ddx = longint'(cen_x[1]) - longint'(cen_x[0]);
        ddy = longint'(cen_y[1]) - longint'(cen_y[0]);
        if (ddx * bnx + ddy * bny < 0) begin
            bnx = -bnx;
            bny = -bny;
        end
        dq = (longint'(best) + 8192) >> 14;
        if (dq > 262143) dq = 262143;
        res.collided = 1'b1;
        res.depth = dq[DepthBits-1:0];
        res.nx = bnx[15:0];
        res.ny = bny[15:0];
        return res;
    endfunction

    // add one accepted item to the predictor; returns 1, with a result, on a set's last item
    function automatic bit absorb_item(logic [1:0] f, logic signed [15:0] x,
                                       logic signed [15:0] y, logic l,
                                       output t_contact res);
        res = '0;
        case (f)
            FUNC_V1: begin
                if (cnt1 < MaxVertices) begin
                    pv_x[cnt1] = x;
                    pv_y[cnt1] = y;
                    cnt1++;
                end
            end
            FUNC_V2: begin
                if (cnt2 < MaxVertices) begin
                    pv_x[MaxVertices+cnt2] = x;
                    pv_y[MaxVertices+cnt2] = y;
                    cnt2++;
                end
            end
            FUNC_C1: begin
                cen_x[0] = x;
                cen_y[0] = y;
            end
            default: begin
                cen_x[1] = x;
                cen_y[1] = y;
            end
        endcase
        if (!l) return 0;
        res = predict_contact();
        cnt1 = 0;
        cnt2 = 0;
        return 1;
    endfunction

    // offer one item after a random gap while gaps are on, and wait until it is taken
    task automatic offer_item(logic [1:0] f, logic signed [15:0] x, logic signed [15:0] y,
                              logic l, logic typed, t_contact typed_res);
        int       gap;
        t_contact res;
        gap = idle_on ? $urandom_range(0, 13) : 0;
        if (gap > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata <= {y, x};
        s_axis_tuser <= f;
        s_axis_tlast <= l;
        do @(posedge i_clk); while (!s_axis_tready);
        sent++;
        if (absorb_item(f, x, y, l, res))
            contact_q.push_back(typed ? typed_res : res);
        if (sent % 50 == 0) idle_on = ~idle_on;
    endtask

    task automatic send_vertex(logic [1:0] f, logic signed [15:0] x, logic signed [15:0] y,
                               logic l);
        offer_item(f, x, y, l, 1'b0, '0);
    endtask

    function automatic logic signed [15:0] near(int c, int r);
        int v;
        v = c + $urandom_range(0, 2 * r) - r;
        if (v > 32767) v = 32767;
        if (v < -32768) v = -32768;
        return v[15:0];
    endfunction

    // one set: mostly two nearby vertex clouds, usually with centres, sometimes noise
    task automatic random_set();
        int          n1, n2, cx, cy, r, sep;
        logic [1:0]  f;
        logic signed [15:0] x, y;
        if ($urandom_range(0, 9) < 8) begin
            n1 = ($urandom_range(0, 9) == 0) ? $urandom_range(9, 11) : $urandom_range(1, 5);
            n2 = ($urandom_range(0, 9) == 0) ? $urandom_range(9, 11) : $urandom_range(1, 5);
            r = ($urandom_range(0, 7) == 0) ? 16000 : $urandom_range(4, 400);
            cx = $signed($urandom_range(0, 40000)) - 20000;
            cy = $signed($urandom_range(0, 40000)) - 20000;
            sep = $urandom_range(0, 2 * r);
            for (int i = 0; i < n1; i++)
                send_vertex(FUNC_V1, near(cx, r), near(cy, r), 1'b0);
            if ($urandom_range(0, 3) != 0)
                send_vertex(FUNC_C1, near(cx, r), near(cy, r), 1'b0);
            if ($urandom_range(0, 3) != 0)
                send_vertex(FUNC_C2, near(cx + sep, r), near(cy, r), 1'b0);
            for (int i = 0; i < n2; i++)
                send_vertex(FUNC_V2, near(cx + sep, r), near(cy + sep / 2, r), i == n2 - 1);
        end else begin
            for (int i = 0; i < $urandom_range(1, 8); i++) begin
                f = 2'($urandom_range(0, 3));
                x = 16'($urandom);
                y = 16'($urandom);
                send_vertex(f, x, y, $urandom_range(0, 7) == 0);
            end
            send_vertex(2'($urandom_range(0, 3)), 16'($urandom), 16'($urandom), 1'b1);
        end
    endtask

    // directed table
    t_row rows [$];
    function automatic t_row row(logic [1:0] f, int x, int y, logic l,
                                 logic typed = 1'b0, t_contact res = '0);
        t_row r;
        r.func = f;
        r.x = x[15:0];
        r.y = y[15:0];
        r.last = l;
        r.typed = typed;
        r.res = res;
        return r;
    endfunction

    initial begin
        cnt1 = 0;
        cnt2 = 0;
        cen_x = '{0, 0};
        cen_y = '{0, 0};
        // empty polygons right after reset: no contact
        rows.push_back(row(FUNC_C1, 0, 0, 1'b1, 1'b1, '0));
        // second polygon empty, most negative corner
        rows.push_back(row(FUNC_V1, -32768, -32768, 1'b1, 1'b1, '0));
        // overlapping squares
        rows.push_back(row(FUNC_V1, 0, 0, 1'b0));
        rows.push_back(row(FUNC_V1, 160, 0, 1'b0));
        rows.push_back(row(FUNC_V1, 160, 160, 1'b0));
        rows.push_back(row(FUNC_V1, 0, 160, 1'b0));
        rows.push_back(row(FUNC_V2, 80, 80, 1'b0));
        rows.push_back(row(FUNC_V2, 240, 80, 1'b0));
        rows.push_back(row(FUNC_V2, 240, 240, 1'b0));
        rows.push_back(row(FUNC_V2, 80, 240, 1'b0));
        rows.push_back(row(FUNC_C1, 80, 80, 1'b0));
        rows.push_back(row(FUNC_C2, 160, 160, 1'b1));
        // far apart triangles: separated
        rows.push_back(row(FUNC_V1, 0, 0, 1'b0));
        rows.push_back(row(FUNC_V1, 16, 0, 1'b0));
        rows.push_back(row(FUNC_V1, 0, 16, 1'b0));
        rows.push_back(row(FUNC_V2, 32767, 32767, 1'b0));
        rows.push_back(row(FUNC_V2, 32700, 32767, 1'b0));
        rows.push_back(row(FUNC_V2, 32767, 32700, 1'b1, 1'b1, '0));
        // every edge zero length: no usable axis
        rows.push_back(row(FUNC_V1, 5, 5, 1'b0));
        rows.push_back(row(FUNC_V1, 5, 5, 1'b0));
        rows.push_back(row(FUNC_V2, 5, 5, 1'b1, 1'b1, '0));
        // full-range two-vertex polygon against a one-vertex polygon, with a new second centre
        rows.push_back(row(FUNC_V1, -32768, -32768, 1'b0));
        rows.push_back(row(FUNC_V1, 32767, -32768, 1'b0));
        rows.push_back(row(FUNC_V2, 0, 32767, 1'b0));
        rows.push_back(row(FUNC_C2, -32768, 32767, 1'b1));

        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        foreach (rows[i])
            offer_item(rows[i].func, rows[i].x, rows[i].y, rows[i].last,
                       rows[i].typed, rows[i].res);
        while (sent < NumItems) random_set();
        s_axis_tvalid <= 1'b0;
        while (contact_q.size() != 0) @(posedge i_clk);
        repeat (50) @(posedge i_clk);
        if (errors == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

    // result side: random ready gaps, one long hold-off to back up the input
    initial begin
        t_contact got, want;
        int       gap;
        @(posedge i_rst_n);
        forever begin
            gap = (received == 4) ? 6000 : (idle_on ? $urandom_range(0, 13) : 0);
            if (gap > 0) begin
                m_axis_tready <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
            m_axis_tready <= 1'b1;
            do @(posedge i_clk); while (!m_axis_tvalid);
            received++;
            got.collided = m_axis_tuser;
            got.depth = m_axis_tdata[17:0];
            got.nx = m_axis_tdata[33:18];
            got.ny = m_axis_tdata[49:34];
            if (contact_q.size() == 0) begin
                errors++;
                $display("%0t: unexpected contact, expected none, actual %h", $time, got);
            end else begin
                want = contact_q.pop_front();
                if (got.collided !== want.collided)
                    $display("%0t: collided expected %0d actual %0d",
                             $time, want.collided, got.collided);
                if (got.depth !== want.depth)
                    $display("%0t: depth expected %0d actual %0d",
                             $time, want.depth, got.depth);
                if (got.nx !== want.nx)
                    $display("%0t: normal_x expected %0d actual %0d", $time, want.nx, got.nx);
                if (got.ny !== want.ny)
                    $display("%0t: normal_y expected %0d actual %0d", $time, want.ny, got.ny);
                if (got !== want) errors++;
            end
        end
    end

    // run limit
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles >= CycleLimit) begin
            $display("CHECKS FAILED");
            $finish;
        end
    end
endmodule
